FILE: rtl/tts_pkg.sv
// Shared widths, limits, defaults and control/status types of the texture tile size planner.
`default_nettype none

package tts_pkg;

  localparam int SIZE_W  = 16;   // bitmap dimension
  localparam int LOG_W   = 4;    // max_tex_log2 register
  localparam int SIDE_W  = 14;   // texture side, up to 8192
  localparam int P_W     = 15;   // search power, may pass one doubling beyond 8192
  localparam int COUNT_W = 16;   // full tile count
  localparam int PAD_W   = 18;   // padded extent
  localparam int DIV_CNT_W = $clog2(SIZE_W);

  localparam logic [LOG_W-1:0] LG_MIN   = 4'd5;
  localparam logic [LOG_W-1:0] LG_MAX   = 4'd13;
  localparam logic [LOG_W-1:0] LG_RESET = 4'd11;

  localparam int DEF_MIN_TEX_SIZE        = 16;
  localparam int DEF_THRESHOLD_TILE_SIZE = 256;
  localparam int DEF_MIN_TILE_SIZE       = 4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;         // capture the size, start the power search
    logic p_double;     // advance the search power
    logic set_zero;     // result is all zero
    logic set_single;   // one tile of the covering power
    logic div_init;     // fix base and stride, start the divide
    logic div_step;     // one restoring divide step
    logic j_double;     // advance the last-tile power
    logic set_exact;    // remainder zero: last tile is the stride
    logic set_rounded;  // last tile is the rounded remainder
    logic emit;         // load the result ports and raise done for one cycle
  } tts_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic big;          // size above the largest texture side
    logic p_over;       // search power above the largest side
    logic p_hit;        // search power covers the size
    logic single_ok;    // covering power may stand as one tile
    logic base_small;   // chosen base leaves no stride
    logic div_last;     // final divide step
    logic rem_zero;     // divide left no remainder
    logic j_hit;        // last-tile power covers the remainder
  } tts_sts_t;

endpackage

`default_nettype wire

FILE: rtl/tts_ctrl.sv
// Sequencing state machine of the texture tile size planner.
`default_nettype none

module tts_ctrl
  import tts_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire tts_sts_t sts,
  output tts_cmd_t      cmd,
  output logic          busy
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DIV,
    ST_LAST,
    ST_FIN
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        priority if (sts.big) begin
          if (sts.base_small) begin
            cmd.set_zero = 1'b1;
            state_next   = ST_FIN;
          end else begin
            cmd.div_init = 1'b1;
            state_next   = ST_DIV;
          end
        end else if (sts.p_over) begin
          cmd.set_zero = 1'b1;
          state_next   = ST_FIN;
        end else if (sts.p_hit) begin
          priority if (sts.single_ok) begin
            cmd.set_single = 1'b1;
            state_next     = ST_FIN;
          end else if (sts.base_small) begin
            cmd.set_zero = 1'b1;
            state_next   = ST_FIN;
          end else begin
            cmd.div_init = 1'b1;
            state_next   = ST_DIV;
          end
        end else begin
          cmd.p_double = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_LAST;
        end
      end
      ST_LAST: begin
        priority if (sts.rem_zero) begin
          cmd.set_exact = 1'b1;
          state_next    = ST_FIN;
        end else if (sts.j_hit) begin
          cmd.set_rounded = 1'b1;
          state_next      = ST_FIN;
        end else begin
          cmd.j_double = 1'b1;
        end
      end
      ST_FIN: begin
        cmd.emit   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != ST_IDLE);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tts_dp.sv
// Datapath of the texture tile size planner: search, divide, rounding and result registers.
`default_nettype none

module tts_dp
  import tts_pkg::*;
#(
  parameter int MIN_TEX_SIZE        = DEF_MIN_TEX_SIZE,
  parameter int THRESHOLD_TILE_SIZE = DEF_THRESHOLD_TILE_SIZE,
  parameter int MIN_TILE_SIZE       = DEF_MIN_TILE_SIZE
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [LOG_W-1:0]   cfg_wdata,
  input  wire logic [SIZE_W-1:0]  bitmap_size,
  input  wire tts_cmd_t           cmd,
  output tts_sts_t                sts,
  output logic                    done,
  output logic                    tiling,
  output logic [SIDE_W-1:0]       base_size,
  output logic [COUNT_W-1:0]      base_count,
  output logic [SIDE_W-1:0]       last_size,
  output logic [PAD_W-1:0]        padded_size
);

  logic [LOG_W-1:0]     max_tex_log2;
  logic [SIZE_W-1:0]    size;
  logic [P_W-1:0]       p;
  logic [SIDE_W-1:0]    base;
  logic [SIDE_W-1:0]    stride;
  logic [SIZE_W-1:0]    q;
  logic [SIDE_W-1:0]    r;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [SIDE_W-1:0]    j;
  logic                 tile;
  logic [COUNT_W-1:0]   count;
  logic [SIDE_W-1:0]    last;

  logic [LOG_W-1:0]     lg;
  logic [SIDE_W-1:0]    maxsz;
  logic [SIDE_W-1:0]    base_sel;
  logic [SIZE_W-1:0]    three_q;
  logic [SIDE_W:0]      r_sh;
  logic                 r_ge;
  logic [SIDE_W-1:0]    r_next;
  logic [COUNT_W+SIDE_W-1:0] prod;

  always_comb begin
    priority if (max_tex_log2 > LG_MAX) begin
      lg = LG_MAX;
    end else if (max_tex_log2 < LG_MIN) begin
      lg = LG_MIN;
    end else begin
      lg = max_tex_log2;
    end
  end

  assign maxsz    = SIDE_W'(1) << lg;
  assign base_sel = sts.big ? maxsz : p[P_W-1:1];
  assign three_q  = SIZE_W'(p >> 1) + SIZE_W'(p >> 2);

  assign sts.big        = size > SIZE_W'(maxsz);
  assign sts.p_over     = p > P_W'(maxsz);
  assign sts.p_hit      = size <= SIZE_W'(p);
  assign sts.single_ok  = (p <= P_W'(THRESHOLD_TILE_SIZE)) || (size > three_q);
  assign sts.base_small = base_sel <= SIDE_W'(MIN_TILE_SIZE);
  assign sts.div_last   = div_cnt == DIV_CNT_W'(SIZE_W - 1);
  assign sts.rem_zero   = r == '0;
  assign sts.j_hit      = r <= j;

  // Restoring divide step: shift in the next dividend bit, subtract where it fits
  assign r_sh   = {r, q[SIZE_W-1]};
  assign r_ge   = r_sh >= {1'b0, stride};
  assign r_next = r_ge ? SIDE_W'(r_sh - {1'b0, stride}) : r_sh[SIDE_W-1:0];

  assign prod = {{SIDE_W{1'b0}}, count} * {{COUNT_W{1'b0}}, base};

  always_ff @(posedge clk) begin
    if (rst) begin
      max_tex_log2 <= LG_RESET;
    end else if (cfg_we) begin
      max_tex_log2 <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      size <= bitmap_size;
      p    <= P_W'(MIN_TEX_SIZE);
    end
    if (cmd.p_double) begin
      p <= p << 1;
    end
    if (cmd.set_zero) begin
      tile  <= 1'b0;
      base  <= '0;
      count <= '0;
      last  <= '0;
    end
    if (cmd.set_single) begin
      tile  <= 1'b0;
      base  <= p[SIDE_W-1:0];
      count <= '0;
      last  <= p[SIDE_W-1:0];
    end
    if (cmd.div_init) begin
      base    <= base_sel;
      stride  <= base_sel - SIDE_W'(MIN_TILE_SIZE);
      q       <= size;
      r       <= '0;
      div_cnt <= '0;
      j       <= SIDE_W'(MIN_TILE_SIZE);
    end
    if (cmd.div_step) begin
      q       <= {q[SIZE_W-2:0], r_ge};
      r       <= r_next;
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
    if (cmd.j_double) begin
      j <= j << 1;
    end
    if (cmd.set_exact) begin
      tile  <= 1'b1;
      count <= (q != '0) ? q - COUNT_W'(1) : '0;
      last  <= stride;
    end
    if (cmd.set_rounded) begin
      tile  <= 1'b1;
      count <= q;
      last  <= j;
    end
    if (cmd.emit) begin
      tiling      <= tile;
      base_size   <= base;
      base_count  <= count;
      last_size   <= last;
      padded_size <= prod[PAD_W-1:0] + PAD_W'(last);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/texture_tile_size_planner.sv
// Top level of the texture tile size planner: controller, datapath and checks.
//
// Usage: raise start with a bitmap dimension on bitmap_size; the item is taken
// at the rising edge where start is high and busy is low. busy then stays high
// until the item is finished, and one result follows on tiling, base_size,
// base_count, last_size and padded_size, marked by done for exactly one cycle.
// The receiver cannot stall, so sample the result while done is high; the
// ports keep it until the next result. A new item may be started in the
// cycle done is shown. The power search doubles from MIN_TEX_SIZE until it
// covers the size (a size above the largest side skips it); a single-tile or
// empty result is then set, while a tiled result runs the 16-step restoring
// divider and, unless the remainder is zero, doubles the last-tile power
// until it covers the remainder. One item is in flight at a time.
// Configuration: cfg_we writes cfg_wdata into max_tex_log2; write only while
// busy is low and no result is pending. Values outside 5 to 13 are clamped.
// Reset: synchronous rst returns to idle, drops done and sets max_tex_log2 to
// 11 (largest side 2048).
`default_nettype none

module texture_tile_size_planner
  import tts_pkg::*;
#(
  parameter int MIN_TEX_SIZE        = DEF_MIN_TEX_SIZE,
  parameter int THRESHOLD_TILE_SIZE = DEF_THRESHOLD_TILE_SIZE,
  parameter int MIN_TILE_SIZE       = DEF_MIN_TILE_SIZE
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [LOG_W-1:0]   cfg_wdata,
  input  wire logic               start,
  input  wire logic [SIZE_W-1:0]  bitmap_size,
  output logic                    busy,
  output logic                    done,
  output logic                    tiling,
  output logic [SIDE_W-1:0]       base_size,
  output logic [COUNT_W-1:0]      base_count,
  output logic [SIDE_W-1:0]       last_size,
  output logic [PAD_W-1:0]        padded_size
);

  tts_cmd_t cmd;
  tts_sts_t sts;

  // Sequencer: search, divide, round, emit
  tts_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Arithmetic and result registers
  tts_dp #(
    .MIN_TEX_SIZE        (MIN_TEX_SIZE),
    .THRESHOLD_TILE_SIZE (THRESHOLD_TILE_SIZE),
    .MIN_TILE_SIZE       (MIN_TILE_SIZE)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .bitmap_size (bitmap_size),
    .cmd         (cmd),
    .sts         (sts),
    .done        (done),
    .tiling      (tiling),
    .base_size   (base_size),
    .base_count  (base_count),
    .last_size   (last_size),
    .padded_size (padded_size)
  );

  // The result strobe only appears once the sequencer is back at rest
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");

  // A taken item always holds the block busy on the next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item taken but block not busy");

  // No two results back to back: each item runs through search and finish first
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for two cycles");

  // An untiled result carries no full tiles
  a_untiled_count: assert property (@(posedge clk) disable iff (rst)
    (done && !tiling) |-> (base_count == '0))
    else $error("untiled result with full tiles");

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the texture tile size planner.
//
// A driver and a monitor run as clocked processes. The driver sends bitmap
// dimensions from a queue that the main initial block fills phase by phase,
// and it predicts the tile plan for each item at the edge where the item is
// taken. The monitor compares every result strobed by done with the oldest
// outstanding plan, field by field.
//
// The largest texture side (max_tex_log2) is changed only between phases,
// once every outstanding plan has come back and the block has had time to
// settle. The settings walk through the legal extremes 5 and 13, the
// clamped codes below and above them (0, 4, 14, 15) and a spread of values
// in between.
//
// Stimulus: a short directed set that covers the single-tile threshold, the
// three-quarter fill rule, sizes above the largest side, exact splits and
// the largest and smallest dimensions, followed by random items biased
// towards power-of-two boundaries, stride multiples and the largest side.
`default_nettype none

module tb;
  import tts_pkg::*;

  localparam int RANDOM_PER_PHASE = 73;
  localparam int SETTLE_CYCLES    = 64;    // settle time after each phase, longer than any item
  localparam int IDLE_LIMIT       = 4000;  // cycles with no item taken and no result
  localparam int REPORT_CAP       = 50;

  typedef struct packed {
    logic               tiling;
    logic [SIDE_W-1:0]  base_size;
    logic [COUNT_W-1:0] base_count;
    logic [SIDE_W-1:0]  last_size;
    logic [PAD_W-1:0]   padded_size;
  } tile_plan_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [LOG_W-1:0]   cfg_wdata = LG_RESET;
  logic               start = 1'b0;
  logic [SIZE_W-1:0]  bitmap_size = '0;
  logic               busy;
  logic               done;
  logic               tiling;
  logic [SIDE_W-1:0]  base_size;
  logic [COUNT_W-1:0] base_count;
  logic [SIDE_W-1:0]  last_size;
  logic [PAD_W-1:0]   padded_size;

  // Dimensions waiting to be sent, and plans waiting for their result.
  logic [SIZE_W-1:0] sizes_to_send [$];
  tile_plan_t        awaited_plans [$];

  // Our copy of max_tex_log2, as last written.
  logic [LOG_W-1:0] side_log2 = LG_RESET;

  bit  steady_send = 1'b0;   // no gaps between items while set
  int  hold_off = 0;
  int  next_gap_len;
  int  idle_cycles = 0;
  int  mismatches = 0;
  int  items_sent = 0;
  int  tiled_seen = 0;
  int  single_seen = 0;
  int  settings_used = 1;
  tile_plan_t got_plan;
  tile_plan_t want_plan;

  // Directed dimensions at the reset setting (largest side 2048).
  int unsigned sizes_at_2048 [14] = '{0, 1, 16, 17, 255, 256, 257, 384, 385, 1025,
                                      2048, 2049, 4088, 65535};
  // Directed dimensions at the smallest side (32): stride 28.
  int unsigned sizes_at_32 [6] = '{28, 29, 32, 33, 56, 57};
  // Directed dimensions at the largest side (8192): stride 8188.
  int unsigned sizes_at_8192 [5] = '{6144, 6145, 8192, 8193, 16376};

  // Settings applied after the reset phase, extremes and clamped codes included.
  logic [LOG_W-1:0] side_settings [12] = '{4'd5, 4'd13, 4'd0, 4'd15, 4'd4, 4'd14,
                                          4'd8, 4'd6, 4'd12, 4'd9, 4'd7, 4'd10};

  texture_tile_size_planner uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .start       (start),
    .bitmap_size (bitmap_size),
    .busy        (busy),
    .done        (done),
    .tiling      (tiling),
    .base_size   (base_size),
    .base_count  (base_count),
    .last_size   (last_size),
    .padded_size (padded_size)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clamp the register code to the legal range and return the largest side.
  function automatic int unsigned largest_side(input logic [LOG_W-1:0] code);
    int unsigned lg;
    lg = code;
    if (lg > LG_MAX) lg = LG_MAX;
    if (lg < LG_MIN) lg = LG_MIN;
    return 32'd1 << lg;
  endfunction

  // Work out the tile plan for one dimension under the given register code.
  function automatic tile_plan_t plan_tiles(input logic [SIZE_W-1:0] size,
                                            input logic [LOG_W-1:0] code);
    tile_plan_t  plan;
    int unsigned side, p, base, stride, count, rem, j, last;
    plan = '0;
    side = largest_side(code);
    base = 0;
    last = 0;
    if (size <= side) begin
      // Search upward for the smallest covering power of two.
      for (p = DEF_MIN_TEX_SIZE; p <= side; p = p << 1) begin
        if (size <= p) begin
          // One tile when small enough, or when over three quarters full.
          if (p <= DEF_THRESHOLD_TILE_SIZE || int'(size) - int'(p >> 1) > int'(p >> 2)) begin
            plan.base_size   = SIDE_W'(p);
            plan.last_size   = SIDE_W'(p);
            plan.padded_size = PAD_W'(p);
            return plan;
          end
          base = p >> 1;
          break;
        end
      end
      // No covering power: leave the plan all zero.
      if (base == 0) return plan;
    end else begin
      base = side;
    end
    // A base that leaves no stride gives an all-zero plan.
    if (base <= DEF_MIN_TILE_SIZE) return plan;
    stride = base - DEF_MIN_TILE_SIZE;
    count  = size / stride;
    rem    = size % stride;
    if (rem == 0) begin
      // Exact split: the last tile is the stride itself; never go below zero.
      if (count > 0) count = count - 1;
      last = stride;
    end else begin
      for (j = DEF_MIN_TILE_SIZE; j <= base; j = j << 1) begin
        if (rem <= j) begin
          last = j;
          break;
        end
      end
    end
    plan.tiling      = 1'b1;
    plan.base_size   = SIDE_W'(base);
    plan.base_count  = COUNT_W'(count);
    plan.last_size   = SIDE_W'(last);
    plan.padded_size = PAD_W'(count * base + last);
    return plan;
  endfunction

  // Pick a random dimension, leaning towards the edges of the decision.
  function automatic logic [SIZE_W-1:0] pick_size();
    int          v;
    int unsigned side, p, stride, mode;
    side   = largest_side(side_log2);
    stride = side - DEF_MIN_TILE_SIZE;
    mode   = $urandom_range(0, 9);
    case (mode)
      0, 1, 2: v = $urandom_range(0, 65535);
      3:       v = $urandom_range(0, 63);
      4, 5:    v = (1 << $urandom_range(4, 15)) + $urandom_range(0, 8) - 4;
      6:       v = $urandom_range(0, 2 * side);
      7:       v = $urandom_range(1, 65535 / stride) * stride + $urandom_range(0, 2) - 1;
      8: begin
        p = 1 << $urandom_range(9, 13);
        v = (p >> 1) + (p >> 2) + $urandom_range(0, 2) - 1;
      end
      default: v = side + $urandom_range(0, 8) - 4;
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return SIZE_W'(v);
  endfunction

  // Gap before the next item: mostly short, a few long.
  function automatic int pick_gap();
    int unsigned r;
    if (steady_send) return 0;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(0, 3);
    if (r < 19) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < REPORT_CAP)
      $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) sizes_to_send.push_back(pick_size());
  endtask

  // Hold until every item is sent and every plan has come back, then let the
  // block settle.
  task automatic drain();
    while (sizes_to_send.size() != 0 || start || awaited_plans.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_side_log2(input logic [LOG_W-1:0] code);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= code;
    side_log2 = code;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Driver: present the head of the queue, predict its plan when it is taken,
  // then either advance straight to the next item or drop start for a gap.
  always @(posedge clk) begin
    if (rst) begin
      start    <= 1'b0;
      hold_off <= 0;
    end else if (start && !busy) begin
      awaited_plans.push_back(plan_tiles(bitmap_size, side_log2));
      void'(sizes_to_send.pop_front());
      items_sent++;
      next_gap_len = pick_gap();
      if (next_gap_len == 0 && sizes_to_send.size() != 0) begin
        bitmap_size <= sizes_to_send[0];
      end else begin
        start    <= 1'b0;
        hold_off <= next_gap_len;
      end
    end else if (!start) begin
      if (hold_off != 0) begin
        hold_off <= hold_off - 1;
      end else if (sizes_to_send.size() != 0) begin
        start       <= 1'b1;
        bitmap_size <= sizes_to_send[0];
      end
    end
  end

  // Monitor: done marks the result for one cycle only, so take it while done is high.
  always @(posedge clk) begin
    if (!rst && done) begin
      got_plan = '{tiling, base_size, base_count, last_size, padded_size};
      if (awaited_plans.size() == 0) begin
        report_mismatch("result with nothing outstanding, base_size", base_size, 0);
      end else begin
        want_plan = awaited_plans.pop_front();
        if (got_plan.tiling != want_plan.tiling)
          report_mismatch("tiling", got_plan.tiling, want_plan.tiling);
        if (got_plan.base_size != want_plan.base_size)
          report_mismatch("base_size", got_plan.base_size, want_plan.base_size);
        if (got_plan.base_count != want_plan.base_count)
          report_mismatch("base_count", got_plan.base_count, want_plan.base_count);
        if (got_plan.last_size != want_plan.last_size)
          report_mismatch("last_size", got_plan.last_size, want_plan.last_size);
        if (got_plan.padded_size != want_plan.padded_size)
          report_mismatch("padded_size", got_plan.padded_size, want_plan.padded_size);
        if (want_plan.tiling) tiled_seen++;
        else single_seen++;
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("no progress for %0d cycles, %0d plans outstanding",
                 IDLE_LIMIT, awaited_plans.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset setting: directed edges first, then random items.
    @(negedge clk);
    foreach (sizes_at_2048[i]) sizes_to_send.push_back(SIZE_W'(sizes_at_2048[i]));
    queue_random(RANDOM_PER_PHASE);

    for (int ph = 0; ph < 12; ph++) begin
      drain();
      write_side_log2(side_settings[ph]);
      settings_used++;
      @(negedge clk);
      steady_send = (ph % 3 == 1);
      if (side_settings[ph] == LG_MIN)
        foreach (sizes_at_32[i]) sizes_to_send.push_back(SIZE_W'(sizes_at_32[i]));
      if (side_settings[ph] == LG_MAX)
        foreach (sizes_at_8192[i]) sizes_to_send.push_back(SIZE_W'(sizes_at_8192[i]));
      queue_random(RANDOM_PER_PHASE);
    end

    drain();
    if (awaited_plans.size() != 0)
      report_mismatch("plans left outstanding", awaited_plans.size(), 0);

    $display("Sent %0d dimensions under %0d largest-side settings", items_sent,
             settings_used);
    $display("Results seen: %0d tiled, %0d single tile or empty, %0d mismatches",
             tiled_seen, single_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
rtl/tts_pkg.sv
rtl/tts_ctrl.sv
rtl/tts_dp.sv
rtl/texture_tile_size_planner.sv
verif/tb.sv
